// File: rtl/bfa_pkg.sv
package bfa_pkg;

  // Default sizing of the block table
  localparam int MAX_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  // Depth of the command queue between front and back
  localparam int CMD_QUEUE_DEPTH = 2;

  // Port field widths
  localparam int CFG_W       = 6;
  localparam int SLOT_W      = 5;
  localparam int SIZE_W      = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 40;
  localparam int M_TDATA_PAD = M_TDATA_W - SLOT_W - 2 * SIZE_W;
  localparam int S_TDATA_PAD = S_TDATA_W - SLOT_W - SIZE_W;

  // Action codes carried on the input tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Command kinds passed from front to back
  typedef enum logic {
    KIND_LOAD,
    KIND_ALLOC
  } cmd_kind_t;

endpackage

// File: rtl/best_fit_block_allocator.sv
// Best-fit block allocator. A load transaction (tuser 0) writes one block's size into the
// table and frees that block; an allocate transaction (tuser 1) searches the first
// block_count blocks for the free block with the smallest non-negative leftover, lowest
// index on a tie, marks it allocated and returns found, index, size and leftover. Every
// input transaction gives exactly one result transaction. After reset the table is swept
// once, clearing every entry, before the first input transaction is taken; configuration
// writes are taken throughout. A load, and an allocate with a block count of zero, pass
// from idle straight to the response state; any other allocate scans the first
// min(block_count, MAX_BLOCKS) blocks through the table memory's single read port, which
// the search walks one block per cycle, then commits. A two-entry command queue lets new
// transactions be taken while a search runs or a result waits on the output.
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel: block_count
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // block_slot[4:0], size_value[20:5], zero pad
  input  logic                 s_tuser,   // action
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // chosen_block[4:0], chosen_size[20:5],
                                          // leftover[36:21], zero pad
  output logic                 m_tuser    // found
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMD_W = 2 + IDX_W + SIZE_BITS + CNT_W;

  logic             init_done;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [CMD_W-1:0] q_data;
  logic [CMD_W-1:0] q_head;

  // Front: take and classify transactions
  bfa_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // Queue: decouple front from back
  bfa_cmd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: table updates, search and result register
  bfa_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_done (init_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfa_front.sv
module bfa_front
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int CMD_W      = 2 + IDX_W + SIZE_BITS + CNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // block_slot[4:0], size_value[20:5], zero pad
  input  logic                 s_tuser,   // action
  // towards the command queue
  input  logic                 init_done,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [CMD_W-1:0]     q_data
);

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   slot_ok;
    logic [IDX_W-1:0]       slot;
    logic [SIZE_BITS-1:0]   size;
    logic [CNT_W-1:0]       limit;
  } cmd_t;

  logic [CFG_W-1:0]  block_count;
  logic [SLOT_W-1:0] in_slot;
  logic [SIZE_W-1:0] in_size;
  cmd_t              cmd;

  // Hold the block count register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Accept only once the table is cleared and the queue has room
  assign s_tready = init_done && !q_full;
  assign q_push   = s_tvalid && s_tready;

  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_size = s_tdata[SLOT_W+SIZE_W-1:SLOT_W];

  // Classify the transaction into a command for the back end
  always_comb begin
    cmd.slot    = IDX_W'(in_slot);
    cmd.size    = SIZE_BITS'(in_size);
    cmd.slot_ok = (32'(in_slot) < MAX_BLOCKS);
    cmd.limit   = (32'(block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(block_count);
    unique case (s_tuser)
      ACT_LOAD:  cmd.kind = KIND_LOAD;
      ACT_ALLOC: cmd.kind = KIND_ALLOC;
      default:   cmd.kind = KIND_LOAD;
    endcase
  end

  assign q_data = cmd;

endmodule

// File: rtl/bfa_cmd_queue.sv
module bfa_cmd_queue
  import bfa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bfa_back.sv
module bfa_back
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int CMD_W      = 2 + IDX_W + SIZE_BITS + CNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  // from the command queue
  input  logic [CMD_W-1:0]     q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 init_done,
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // chosen_block[4:0], chosen_size[20:5],
                                          // leftover[36:21], zero pad
  output logic                 m_tuser    // found
);

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   slot_ok;
    logic [IDX_W-1:0]       slot;
    logic [SIZE_BITS-1:0]   size;
    logic [CNT_W-1:0]       limit;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  localparam int ENT_W = SIZE_BITS + 1;

  state_t               state;
  cmd_t                 cmd;
  logic [IDX_W-1:0]     clr_idx;
  logic [SIZE_BITS-1:0] req;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     iss_idx;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic                 hit;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] best_left;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  logic                 issue;
  logic                 ent_mark;
  logic [SIZE_BITS-1:0] ent_size;
  logic [SIZE_BITS-1:0] ent_left;
  logic                 better;

  logic                 found_out;
  logic [SLOT_W-1:0]    block_out;
  logic [SIZE_W-1:0]    size_out;
  logic [SIZE_W-1:0]    left_out;

  assign cmd       = q_head;
  assign init_done = (state != ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign issue     = (state == ST_SCAN) && (iss_idx < limit);

  // Each table entry holds the allocated mark over the block size
  bfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Drive the table write port by phase
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    ram_raddr = iss_idx[IDX_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (!q_empty && cmd.kind == KIND_LOAD && cmd.slot_ok) begin
          ram_we    = 1'b1;
          ram_waddr = cmd.slot;
          ram_wdata = {1'b0, cmd.size};
        end
      end
      ST_COMMIT: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_waddr = best_idx;
          ram_wdata = {1'b1, best_size};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Compare the entry read back against the best so far
  always_comb begin
    ent_mark = ram_rdata[SIZE_BITS];
    ent_size = ram_rdata[SIZE_BITS-1:0];
    ent_left = ent_size - req;
    better   = !ent_mark && (ent_size >= req) && (!hit || (ent_left < best_left));
  end

  // Fit the result to the port widths
  always_comb begin
    found_out = hit;
    block_out = SLOT_W'(best_idx);
    size_out  = SIZE_W'(best_size);
    left_out  = SIZE_W'(best_left);
  end

  // Sequence clear, load, scan, commit and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      chk_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded below
      if (m_tready && state != ST_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(MAX_BLOCKS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            hit       <= 1'b0;
            best_idx  <= '0;
            best_size <= '0;
            best_left <= '0;
            req       <= cmd.size;
            limit     <= cmd.limit;
            iss_idx   <= '0;
            chk_valid <= 1'b0;
            if (cmd.kind == KIND_ALLOC && cmd.limit != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle, check the entry read the cycle before
          chk_valid <= issue;
          chk_idx   <= iss_idx[IDX_W-1:0];
          if (issue) begin
            iss_idx <= iss_idx + 1'b1;
          end
          if (chk_valid && better) begin
            hit       <= 1'b1;
            best_idx  <= chk_idx;
            best_size <= ent_size;
            best_left <= ent_left;
          end
          if (!issue && !chk_valid) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= found_out;
            m_tdata  <= {{M_TDATA_PAD{1'b0}}, left_out, size_out, block_out};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
